// ===== rtl/e84cal_pkg.sv =====
// ============================================================================
// e84cal_pkg
// Types, constants and the microcode table for the day-count to calendar
// date and time-of-day converter.
// ============================================================================
package e84cal_pkg;

    // Field widths
    localparam int DAY_W   = 16;
    localparam int MS_W    = 27;
    localparam int YEAR_W  = 12;
    localparam int MON_W   = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 6;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MSEC_W  = 10;

    // Remaining day number is days + 1, so one bit more than the count
    localparam int DREM_W  = DAY_W + 1;
    localparam int YLEN_W  = 9;
    localparam int Y100_W  = 7;
    localparam int Y400_W  = 9;

    // Calendar constants
    localparam logic [YEAR_W-1:0] BASE_YEAR      = 12'd1984;
    localparam logic [Y100_W-1:0] BASE_YEAR_M100 = 7'd84;
    localparam logic [Y400_W-1:0] BASE_YEAR_M400 = 9'd384;
    localparam logic [Y100_W-1:0] LAST_M100      = 7'd99;
    localparam logic [Y400_W-1:0] LAST_M400      = 9'd399;
    localparam logic [YLEN_W-1:0] DAYS_COMMON    = 9'd365;
    localparam logic [YLEN_W-1:0] DAYS_LEAP      = 9'd366;
    localparam logic [MON_W-1:0]  LAST_MONTH     = 4'd11;

    // Time constants
    localparam logic [MS_W-1:0] MS_PER_HOUR   = 27'd3600000;
    localparam logic [MS_W-1:0] MS_PER_MINUTE = 27'd60000;
    localparam logic [MS_W-1:0] MS_PER_SECOND = 27'd1000;
    localparam logic [MS_W-1:0] MS_PER_DAY    = 27'd86400000;

    // Microcode step addresses
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_LOAD  = 3'd0;
    localparam t_step STEP_YEAR  = 3'd1;
    localparam t_step STEP_MONTH = 3'd2;
    localparam t_step STEP_HOUR  = 3'd3;
    localparam t_step STEP_MIN   = 3'd4;
    localparam t_step STEP_SEC   = 3'd5;
    localparam t_step STEP_OUT   = 3'd6;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_YEAR,
        OP_MONTH,
        OP_HOUR,
        OP_MIN,
        OP_SEC,
        OP_OUT
    } t_op;

    // Branch condition of one step
    typedef enum logic [2:0] {
        COND_IN_VALID,
        COND_YEAR_MORE,
        COND_MONTH_MORE,
        COND_HOUR_MORE,
        COND_MIN_MORE,
        COND_SEC_MORE,
        COND_OUT_FREE
    } t_cond;

    // One control word: operation, condition, and both branch targets
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step nxt_t;
        t_step nxt_f;
    } t_uword;

    // Program: each loop step repeats itself while its condition holds
    function automatic t_uword ucode_rom(input t_step addr);
        t_uword w;
        unique case (addr)
            STEP_LOAD:  w = '{OP_LOAD,  COND_IN_VALID,   STEP_YEAR,  STEP_LOAD};
            STEP_YEAR:  w = '{OP_YEAR,  COND_YEAR_MORE,  STEP_YEAR,  STEP_MONTH};
            STEP_MONTH: w = '{OP_MONTH, COND_MONTH_MORE, STEP_MONTH, STEP_HOUR};
            STEP_HOUR:  w = '{OP_HOUR,  COND_HOUR_MORE,  STEP_HOUR,  STEP_MIN};
            STEP_MIN:   w = '{OP_MIN,   COND_MIN_MORE,   STEP_MIN,   STEP_SEC};
            STEP_SEC:   w = '{OP_SEC,   COND_SEC_MORE,   STEP_SEC,   STEP_OUT};
            STEP_OUT:   w = '{OP_OUT,   COND_OUT_FREE,   STEP_LOAD,  STEP_OUT};
            default:    w = '{OP_LOAD,  COND_IN_VALID,   STEP_LOAD,  STEP_LOAD};
        endcase
        return w;
    endfunction

    // Month length, January is month 0
    function automatic logic [DOM_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DOM_W-1:0] len;
        unique case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/epoch_1984_timestamp_to_calendar.sv =====
// The subtract-and-count loops of the microcode sequencer strip whole years
//   past 1984 (up to 179), months into the year (up to 11), hours (up to 37),
//   minutes and seconds (up to 59 each), one per pass. No new request is taken
//   until the last result is in the output register; a new request is taken
//   while a result waits.
// Reset: synchronous, active low; clears the step counter and the output valid.
// ============================================================================
// epoch_1984_timestamp_to_calendar
// Converts a day count since 1984-01-01 and a millisecond-of-day count into
// Gregorian year, month, day, and hour, minute, second, millisecond.
// ============================================================================
module epoch_1984_timestamp_to_calendar (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [e84cal_pkg::DAY_W-1:0]        i_day_count,
    input  logic [e84cal_pkg::MS_W-1:0]         i_ms_of_day,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [e84cal_pkg::YEAR_W-1:0]       o_year,
    output logic [e84cal_pkg::MON_W-1:0]        o_month,
    output logic [e84cal_pkg::DOM_W-1:0]        o_day_of_month,
    output logic [e84cal_pkg::HOUR_W-1:0]       o_hour,
    output logic [e84cal_pkg::MIN_W-1:0]        o_minute,
    output logic [e84cal_pkg::SEC_W-1:0]        o_second,
    output logic [e84cal_pkg::MSEC_W-1:0]       o_millisecond,
    output logic                                o_time_invalid
);

    // Sequencer
    e84cal_pkg::t_step  r_step;
    e84cal_pkg::t_step  n_step;
    e84cal_pkg::t_uword uword;
    logic               cond;

    // Working registers
    logic [e84cal_pkg::DREM_W-1:0] r_day;
    logic [e84cal_pkg::YEAR_W-1:0] r_year;
    logic [e84cal_pkg::Y100_W-1:0] r_ym100;
    logic [e84cal_pkg::Y400_W-1:0] r_ym400;
    logic [e84cal_pkg::MON_W-1:0]  r_month;
    logic [e84cal_pkg::MS_W-1:0]   r_ms;
    logic [e84cal_pkg::HOUR_W-1:0] r_hour;
    logic [e84cal_pkg::MIN_W-1:0]  r_min;
    logic [e84cal_pkg::SEC_W-1:0]  r_sec;
    logic                          r_inval;

    // Output register
    logic                           r_o_valid;
    logic [e84cal_pkg::YEAR_W-1:0]  r_o_year;
    logic [e84cal_pkg::MON_W-1:0]   r_o_month;
    logic [e84cal_pkg::DOM_W-1:0]   r_o_dom;
    logic [e84cal_pkg::HOUR_W-1:0]  r_o_hour;
    logic [e84cal_pkg::MIN_W-1:0]   r_o_min;
    logic [e84cal_pkg::SEC_W-1:0]   r_o_sec;
    logic [e84cal_pkg::MSEC_W-1:0]  r_o_msec;
    logic                           r_o_inval;

    // Datapath helpers
    logic                          leap;
    logic [e84cal_pkg::YLEN_W-1:0] ylen;
    logic [e84cal_pkg::DOM_W-1:0]  mlen;
    logic [e84cal_pkg::DREM_W-1:0] ylen_x;
    logic [e84cal_pkg::DREM_W-1:0] mlen_x;

    // Full leap rule from running mod-100 and mod-400 counters
    assign leap   = (r_year[1:0] == 2'd0) && ((r_ym100 != '0) || (r_ym400 == '0));
    assign ylen   = leap ? e84cal_pkg::DAYS_LEAP : e84cal_pkg::DAYS_COMMON;
    assign mlen   = e84cal_pkg::month_len(r_month, leap);
    assign ylen_x = {{(e84cal_pkg::DREM_W - e84cal_pkg::YLEN_W){1'b0}}, ylen};
    assign mlen_x = {{(e84cal_pkg::DREM_W - e84cal_pkg::DOM_W){1'b0}}, mlen};

    // Control word fetch and branch condition
    always_comb begin
        uword = e84cal_pkg::ucode_rom(r_step);
        unique case (uword.cond)
            e84cal_pkg::COND_IN_VALID:   cond = i_valid;
            e84cal_pkg::COND_YEAR_MORE:  cond = r_day > ylen_x;
            e84cal_pkg::COND_MONTH_MORE: cond = (r_month < e84cal_pkg::LAST_MONTH)
                                                && (r_day > mlen_x);
            e84cal_pkg::COND_HOUR_MORE:  cond = r_ms >= e84cal_pkg::MS_PER_HOUR;
            e84cal_pkg::COND_MIN_MORE:   cond = r_ms >= e84cal_pkg::MS_PER_MINUTE;
            e84cal_pkg::COND_SEC_MORE:   cond = r_ms >= e84cal_pkg::MS_PER_SECOND;
            e84cal_pkg::COND_OUT_FREE:   cond = !r_o_valid || i_ready;
            default:                     cond = 1'b0;
        endcase
        n_step = cond ? uword.nxt_t : uword.nxt_f;
    end

    assign o_ready = (uword.op == e84cal_pkg::OP_LOAD);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= e84cal_pkg::STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    // Datapath: each op acts only when its condition holds
    always_ff @(posedge i_clk) begin
        if (cond) begin
            unique case (uword.op)
                e84cal_pkg::OP_LOAD: begin
                    r_day   <= {1'b0, i_day_count} + 1'b1;
                    r_year  <= e84cal_pkg::BASE_YEAR;
                    r_ym100 <= e84cal_pkg::BASE_YEAR_M100;
                    r_ym400 <= e84cal_pkg::BASE_YEAR_M400;
                    r_month <= '0;
                    r_ms    <= i_ms_of_day;
                    r_hour  <= '0;
                    r_min   <= '0;
                    r_sec   <= '0;
                    r_inval <= i_ms_of_day >= e84cal_pkg::MS_PER_DAY;
                end
                e84cal_pkg::OP_YEAR: begin
                    r_day   <= r_day - ylen_x;
                    r_year  <= r_year + 1'b1;
                    r_ym100 <= (r_ym100 == e84cal_pkg::LAST_M100) ? '0 : r_ym100 + 1'b1;
                    r_ym400 <= (r_ym400 == e84cal_pkg::LAST_M400) ? '0 : r_ym400 + 1'b1;
                end
                e84cal_pkg::OP_MONTH: begin
                    r_day   <= r_day - mlen_x;
                    r_month <= r_month + 1'b1;
                end
                e84cal_pkg::OP_HOUR: begin
                    r_ms   <= r_ms - e84cal_pkg::MS_PER_HOUR;
                    r_hour <= r_hour + 1'b1;
                end
                e84cal_pkg::OP_MIN: begin
                    r_ms  <= r_ms - e84cal_pkg::MS_PER_MINUTE;
                    r_min <= r_min + 1'b1;
                end
                e84cal_pkg::OP_SEC: begin
                    r_ms  <= r_ms - e84cal_pkg::MS_PER_SECOND;
                    r_sec <= r_sec + 1'b1;
                end
                e84cal_pkg::OP_OUT: begin
                    r_o_year  <= r_year;
                    r_o_month <= r_month + 1'b1;
                    r_o_dom   <= r_day[e84cal_pkg::DOM_W-1:0];
                    r_o_hour  <= r_hour;
                    r_o_min   <= r_min;
                    r_o_sec   <= r_sec;
                    r_o_msec  <= r_ms[e84cal_pkg::MSEC_W-1:0];
                    r_o_inval <= r_inval;
                end
                default: begin
                end
            endcase
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((uword.op == e84cal_pkg::OP_OUT) && cond) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day_of_month = r_o_dom;
    assign o_hour         = r_o_hour;
    assign o_minute       = r_o_min;
    assign o_second       = r_o_sec;
    assign o_millisecond  = r_o_msec;
    assign o_time_invalid = r_o_inval;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the day-count to calendar converter. A directed
// table of timestamps is walked first, then random requests under three
// idling patterns; every result is checked against a hand-written result or a local calendar model.
// ============================================================================
module tb;

    localparam int    CLK_PERIOD     = 12;
    localparam int    RESET_CYCLES   = 12;
    localparam int    RANDOM_PER_PH  = 650;
    localparam int    DRAIN_CYCLES   = 400;
    localparam longint TIMEOUT_CYCLES = 4_000_000;

    // Calendar and time constants for the local model
    localparam int unsigned FIRST_YEAR  = 1984;
    localparam int unsigned MS_HOUR     = 3600000;
    localparam int unsigned MS_MINUTE   = 60000;
    localparam int unsigned MS_SECOND   = 1000;
    localparam int unsigned MS_FULL_DAY = 86400000;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [e84cal_pkg::YEAR_W-1:0] year;
        logic [e84cal_pkg::MON_W-1:0]  month;
        logic [e84cal_pkg::DOM_W-1:0]  dom;
        logic [e84cal_pkg::HOUR_W-1:0] hour;
        logic [e84cal_pkg::MIN_W-1:0]  minute;
        logic [e84cal_pkg::SEC_W-1:0]  second;
        logic [e84cal_pkg::MSEC_W-1:0] msec;
        logic                          bad_time;
    } t_cal_result;

    // One row of the directed table; fixed_exp holds a hand-written result
    typedef struct {
        logic [e84cal_pkg::DAY_W-1:0] day;
        logic [e84cal_pkg::MS_W-1:0]  ms;
        bit                           typed;
        t_cal_result                  fixed_exp;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [e84cal_pkg::DAY_W-1:0]   i_day_count;
    logic [e84cal_pkg::MS_W-1:0]    i_ms_of_day;
    logic                           o_valid;
    logic                           i_ready;
    logic [e84cal_pkg::YEAR_W-1:0]  o_year;
    logic [e84cal_pkg::MON_W-1:0]   o_month;
    logic [e84cal_pkg::DOM_W-1:0]   o_day_of_month;
    logic [e84cal_pkg::HOUR_W-1:0]  o_hour;
    logic [e84cal_pkg::MIN_W-1:0]   o_minute;
    logic [e84cal_pkg::SEC_W-1:0]   o_second;
    logic [e84cal_pkg::MSEC_W-1:0]  o_millisecond;
    logic                           o_time_invalid;

    t_cal_result cal_expect_q [$];
    t_stim_row   directed_tab [$];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    epoch_1984_timestamp_to_calendar i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_day_count    (i_day_count),
        .i_ms_of_day    (i_ms_of_day),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_millisecond  (o_millisecond),
        .o_time_invalid (o_time_invalid)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb: errors");
        $finish;
    end

    // Gregorian leap-year rule, centuries included
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Calendar date and time of day for one timestamp
    function automatic t_cal_result predict_calendar(
            input logic [e84cal_pkg::DAY_W-1:0] day,
            input logic [e84cal_pkg::MS_W-1:0]  ms);
        t_cal_result r;
        int unsigned yr;
        int unsigned rem;
        int unsigned mon;
        int unsigned msv;
        bit          leap;
        yr  = FIRST_YEAR;
        rem = int'(day) + 1;
        mon = 0;
        msv = int'(ms);
        // strip whole years
        while (rem > (is_leap(yr) ? 366 : 365)) begin
            rem -= is_leap(yr) ? 366 : 365;
            yr++;
        end
        // strip whole months, December takes the remainder
        leap = is_leap(yr);
        while (mon < 11 && rem > ((mon == 1 && leap) ? 29 : MONTH_DAYS[mon])) begin
            rem -= (mon == 1 && leap) ? 29 : MONTH_DAYS[mon];
            mon++;
        end
        r.year     = yr[e84cal_pkg::YEAR_W-1:0];
        r.month    = 4'(mon + 1);
        r.dom      = rem[e84cal_pkg::DOM_W-1:0];
        r.hour     = 6'(msv / MS_HOUR);
        r.minute   = 6'((msv % MS_HOUR) / MS_MINUTE);
        r.second   = 6'((msv % MS_MINUTE) / MS_SECOND);
        r.msec     = 10'(msv % MS_SECOND);
        r.bad_time = (msv >= MS_FULL_DAY);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic add_row(input logic [e84cal_pkg::DAY_W-1:0] day,
                           input logic [e84cal_pkg::MS_W-1:0] ms,
                           input bit typed, input t_cal_result fixed_exp);
        t_stim_row row;
        row.day       = day;
        row.ms        = ms;
        row.typed     = typed;
        row.fixed_exp = fixed_exp;
        directed_tab.push_back(row);
    endtask

    // Offer one request; returns at the edge where it is taken.
    // Valid is only dropped when an idle gap is chosen.
    task automatic send_timestamp(input logic [e84cal_pkg::DAY_W-1:0] day,
                                  input logic [e84cal_pkg::MS_W-1:0] ms,
                                  input bit typed, input t_cal_result fixed_exp);
        bit gap_started;
        gap_started = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            if (!gap_started) i_valid <= 1'b0;
            gap_started = 1'b1;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_day_count <= day;
        i_ms_of_day <= ms;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        cal_expect_q.push_back(typed ? fixed_exp : predict_calendar(day, ms));
    endtask

    // Result side: check what is taken, then pick the next ready
    always @(posedge i_clk) begin : result_side
        t_cal_result got;
        t_cal_result want;
        string       diff;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_year, o_month, o_day_of_month, o_hour, o_minute,
                    o_second, o_millisecond, o_time_invalid};
            if (cal_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = cal_expect_q.pop_front();
                diff = "";
                if (got.year     !== want.year)     diff = {diff, " year"};
                if (got.month    !== want.month)    diff = {diff, " month"};
                if (got.dom      !== want.dom)      diff = {diff, " day_of_month"};
                if (got.hour     !== want.hour)     diff = {diff, " hour"};
                if (got.minute   !== want.minute)   diff = {diff, " minute"};
                if (got.second   !== want.second)   diff = {diff, " second"};
                if (got.msec     !== want.msec)     diff = {diff, " millisecond"};
                if (got.bad_time !== want.bad_time) diff = {diff, " time_invalid"};
                if (diff != "")
                    report_mismatch($sformatf("mismatch in%s: got %p, want %p",
                                              diff, got, want));
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stimulus
    initial begin
        logic [e84cal_pkg::DAY_W-1:0] r_day;
        logic [e84cal_pkg::MS_W-1:0]  r_ms;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_ready     <= 1'b0;
        i_day_count <= '0;
        i_ms_of_day <= '0;

        // Directed table: extremes, leap days, century rule, invalid time
        add_row(16'd0,     27'd0,         1'b1, '{12'd1984, 4'd1,  5'd1,  6'd0,  6'd0,
                                                  6'd0,  10'd0,   1'b0});
        add_row(16'd65535, 27'd134217727, 1'b1, '{12'd2163, 4'd6,  5'd6,  6'd37, 6'd16,
                                                  6'd57, 10'd727, 1'b1});
        add_row(16'd0,     27'd86399999,  1'b1, '{12'd1984, 4'd1,  5'd1,  6'd23, 6'd59,
                                                  6'd59, 10'd999, 1'b0});
        add_row(16'd0,     27'd86400000,  1'b1, '{12'd1984, 4'd1,  5'd1,  6'd24, 6'd0,
                                                  6'd0,  10'd0,   1'b1});
        add_row(16'd365,   27'd0,         1'b1, '{12'd1984, 4'd12, 5'd31, 6'd0,  6'd0,
                                                  6'd0,  10'd0,   1'b0});
        add_row(16'd366,   27'd0,         1'b1, '{12'd1985, 4'd1,  5'd1,  6'd0,  6'd0,
                                                  6'd0,  10'd0,   1'b0});
        add_row(16'd59,    27'd0,         1'b1, '{12'd1984, 4'd2,  5'd29, 6'd0,  6'd0,
                                                  6'd0,  10'd0,   1'b0});
        add_row(16'd60,    27'd0,         1'b1, '{12'd1984, 4'd3,  5'd1,  6'd0,  6'd0,
                                                  6'd0,  10'd0,   1'b0});
        add_row(16'd364,   27'd3599999,   1'b0, '0);
        add_row(16'd730,   27'd3600000,   1'b0, '0);
        add_row(16'd5903,  27'd59999,     1'b0, '0);
        add_row(16'd6209,  27'd60000,     1'b0, '0);
        add_row(16'd42368, 27'd999,       1'b0, '0);
        add_row(16'd42427, 27'd1000,      1'b0, '0);
        add_row(16'd42428, 27'd43200000,  1'b0, '0);
        add_row(16'd65534, 27'd86400001,  1'b0, '0);
        add_row(16'd32768, 27'h4000000,   1'b0, '0);
        add_row(16'h5555,  27'h2AAAAAA,   1'b0, '0);
        add_row(16'hAAAA,  27'h5555555,   1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tab[i])
            send_timestamp(directed_tab[i].day, directed_tab[i].ms,
                           directed_tab[i].typed, directed_tab[i].fixed_exp);

        // Random requests under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PH) begin
                // a quarter early dates keeps the year loop short
                if ($urandom_range(3) == 0) r_day = 16'($urandom_range(0, 1500));
                else                        r_day = 16'($urandom());
                case ($urandom_range(15))
                    0:       r_ms = 27'($urandom_range(MS_FULL_DAY, 134217727));
                    1:       r_ms = 27'($urandom());
                    default: r_ms = 27'($urandom_range(0, MS_FULL_DAY - 1));
                endcase
                send_timestamp(r_day, r_ms, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        // Drain, then allow for anything still in flight
        while (cal_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && cal_expect_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== epoch_1984_timestamp_to_calendar.f =====
rtl/e84cal_pkg.sv
rtl/epoch_1984_timestamp_to_calendar.sv
sim/tb.sv
